// ===== design/tce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_pkg
// Shared constants and helpers for the timestamp clock estimator.
// ----------------------------------------------------------------------------
package tce_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 16;
  localparam int unsigned TS_W  = 63;
  localparam int unsigned EST_W = 64;
  localparam int unsigned METH_W = 3;

  localparam logic [METH_W-1:0] METH_EMPTY   = 3'd0;
  localparam logic [METH_W-1:0] METH_CREATED = 3'd1;
  localparam logic [METH_W-1:0] METH_EXACT   = 3'd2;
  localparam logic [METH_W-1:0] METH_CBASED  = 3'd3;
  localparam logic [METH_W-1:0] METH_NEAREST = 3'd4;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  function automatic logic [EST_W-1:0] sx63(input logic [TS_W-1:0] v);
    sx63 = {v[TS_W-1], v};
  endfunction

endpackage

// ===== design/tce_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module tce_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/tce_muldiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_muldiv
// Bit-serial exact 64x64 product followed by restoring 128/64 division.
// ----------------------------------------------------------------------------
module tce_muldiv (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  logic [63:0] d_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [63:0] q_o
);

  logic         busy_q, busy_d, div_q, div_d, done_q, done_d;
  logic [6:0]   cnt_q, cnt_d;
  logic [63:0]  a_q, a_d, d_q, d_d, r_q, r_d;
  logic [127:0] p_q, p_d;
  logic [64:0]  sum;
  logic [63:0]  rr;
  logic         ge;

  always_comb begin
    sum = {1'b0, p_q[127:64]} + (p_q[0] ? {1'b0, a_q} : 65'd0);
    rr  = {r_q[62:0], p_q[127]};
    ge  = rr >= d_q;
    busy_d = busy_q;
    div_d  = div_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    d_d    = d_q;
    r_d    = r_q;
    p_d    = p_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      div_d  = 1'b0;
      cnt_d  = 7'd0;
      a_d    = a_i;
      d_d    = d_i;
      r_d    = 64'd0;
      p_d    = {64'd0, b_i};
    end else if (busy_q && !div_q) begin
      p_d   = {sum, p_q[63:1]};
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        div_d = 1'b1;
        cnt_d = 7'd0;
      end
    end else if (busy_q) begin
      p_d   = {p_q[126:0], ge};
      r_d   = ge ? rr - d_q : rr;
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd127) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else begin
      busy_q <= busy_d;
      div_q  <= div_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    d_q <= d_d;
    r_q <= r_d;
    p_q <= p_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign q_o    = p_q[63:0];

endmodule

// ===== design/timestamp_clock_estimator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_clock_estimator
// Ring of (dts, clock) pairs in RAM; queries scan it for a clock estimate.
// ----------------------------------------------------------------------------
//  channel | handshake                  | word
//  in      | in_valid_i / in_stall_o    | cmd, dts, pair_clock, created*
//  out     | out_valid_o / out_stall_i  | clock_estimate, method
//
//  Push: written to RAM from ST_IDLE; state stays idle. Query on empty ring: ST_IDLE, then ST_FIN.
//  Query scan: per stored pair, RAM read (ST_RD), then compare (ST_EV), up to DEPTH pairs.
//  Created query: ST_CALC picks the path; interpolation then runs the serial unit's
//  multiply, divide and done steps in ST_MUL.
//  Reset clears the fill count and newest pointer; RAM contents are not cleared.
//  Output stall holds the finished word; a query that finishes meanwhile waits in ST_FIN, input stalled.
// ----------------------------------------------------------------------------
module timestamp_clock_estimator #(
  parameter int unsigned STORE_DEPTH = tce_pkg::STORE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cmd_i,
  input  logic [tce_pkg::TS_W-1:0]    dts_i,
  input  logic [tce_pkg::TS_W-1:0]    pair_clock_i,
  input  logic                        created_valid_i,
  input  logic [tce_pkg::TS_W-1:0]    created_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tce_pkg::EST_W-1:0]   clock_estimate_o,
  output logic [tce_pkg::METH_W-1:0]  method_o
);

  localparam int unsigned IW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(STORE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(STORE_DEPTH);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_EV   = 3'd2;
  localparam logic [2:0] ST_CALC = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] fill_q, fill_d, k_q, k_d;
  logic [IW-1:0] newest_q, newest_d, slot_q, slot_d;
  logic          cv_q, cv_d, have_q, have_d, hn_q, hn_d, hp_q, hp_d, exact_q, exact_d;
  logic [63:0]   dts_q, dts_d, cre_q, cre_d, best_q, best_d, est_q, est_d;
  logic [63:0]   nclk_q, nclk_d, ndts_q, ndts_d, pclk_q, pclk_d, pdts_q, pdts_d;
  logic [2:0]    meth_q, meth_d;
  logic          ovalid_q, ovalid_d;
  logic [63:0]   oest_q, oest_d;
  logic [2:0]    ometh_q, ometh_d;

  logic          we, in_acc, out_free, md_start, md_busy, md_done;
  logic [IW-1:0] waddr;
  logic [125:0]  rdata;
  logic [63:0]   sd, sc, diff, dist_abs, crange, drange, num, md_q, qs, inp;
  logic          last, upd, stop;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !ovalid_q || !out_stall_i;
  assign we       = in_acc && (cmd_i == tce_pkg::CMD_PUSH);
  assign waddr    = (fill_q == '0) ? '0 : ((newest_q == LAST_IDX) ? '0 : newest_q + 1'b1);

  tce_ram #(.WIDTH(126), .DEPTH(STORE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({dts_i, pair_clock_i}),
    .raddr_i (slot_q),
    .rdata_o (rdata)
  );

  assign crange = nclk_q - pclk_q;
  assign drange = ndts_q - pdts_q;
  assign num    = nclk_q - cre_q;

  tce_muldiv u_md (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .a_i     (num),
    .b_i     (drange[63] ? 64'd0 - drange : drange),
    .d_i     (crange),
    .busy_o  (md_busy),
    .done_o  (md_done),
    .q_o     (md_q)
  );

  always_comb begin
    sd   = tce_pkg::sx63(rdata[125:63]);
    sc   = tce_pkg::sx63(rdata[62:0]);
    diff = dts_q - sd;
    dist_abs = diff[63] ? 64'd0 - diff : diff;
    last = (k_q == fill_q - 1'b1);
    qs   = drange[63] ? 64'd0 - md_q : md_q;
    inp  = (hp_q && hn_q) ? dts_q : (hp_q ? pdts_q : (hn_q ? ndts_q : dts_q));
    upd  = 1'b0;
    stop = 1'b0;
    md_start = 1'b0;
    state_d = state_q;
    fill_d = fill_q; k_d = k_q; newest_d = newest_q; slot_d = slot_q;
    cv_d = cv_q; have_d = have_q; hn_d = hn_q; hp_d = hp_q; exact_d = exact_q;
    dts_d = dts_q; cre_d = cre_q; best_d = best_q; est_d = est_q; meth_d = meth_q;
    nclk_d = nclk_q; ndts_d = ndts_q; pclk_d = pclk_q; pdts_d = pdts_q;
    ovalid_d = ovalid_q && out_stall_i;
    oest_d = oest_q; ometh_d = ometh_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && cmd_i == tce_pkg::CMD_PUSH) begin
          newest_d = waddr;
          if (fill_q != FULL_CNT) begin
            fill_d = fill_q + 1'b1;
          end
        end else if (in_acc) begin
          dts_d = tce_pkg::sx63(dts_i);
          cre_d = tce_pkg::sx63(created_i);
          cv_d = created_valid_i;
          have_d = 1'b0; hn_d = 1'b0; hp_d = 1'b0; exact_d = 1'b0;
          k_d = '0;
          slot_d = newest_q;
          if (fill_q == '0) begin
            est_d  = created_valid_i ? tce_pkg::sx63(created_i) : 64'd0;
            meth_d = created_valid_i ? tce_pkg::METH_CREATED : tce_pkg::METH_EMPTY;
            state_d = ST_FIN;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_d = ST_EV;
      end
      ST_EV: begin
        if (!cv_q) begin
          upd = !have_q || dist_abs < best_q;
          stop = upd && dist_abs == 64'd0;
          if (upd) begin
            have_d = 1'b1;
            best_d = dist_abs;
            est_d  = diff + sc;
          end
          meth_d = tce_pkg::METH_NEAREST;
        end else if ($signed(cre_q) < $signed(sc)) begin
          if (!hn_q || $signed(sc) < $signed(nclk_q)) begin
            hn_d = 1'b1; nclk_d = sc; ndts_d = sd;
          end
        end else begin
          stop = 1'b1;
          hp_d = 1'b1; pclk_d = sc; pdts_d = sd;
          exact_d = (sd == dts_q);
        end
        if (stop || last) begin
          state_d = cv_q ? ST_CALC : ST_FIN;
        end else begin
          k_d = k_q + 1'b1;
          slot_d = (slot_q == '0) ? LAST_IDX : slot_q - 1'b1;
          state_d = ST_RD;
        end
      end
      ST_CALC: begin
        if (exact_q) begin
          est_d = pclk_q; meth_d = tce_pkg::METH_EXACT;
          state_d = ST_FIN;
        end else if (hp_q && hn_q && crange != 64'd0 && !crange[63]) begin
          md_start = 1'b1;
          state_d = ST_MUL;
        end else begin
          est_d = cre_q + (dts_q - inp); meth_d = tce_pkg::METH_CBASED;
          state_d = ST_FIN;
        end
      end
      ST_MUL: begin
        if (md_done) begin
          est_d = cre_q + (dts_q - (ndts_q - qs)); meth_d = tce_pkg::METH_CBASED;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          ovalid_d = 1'b1; oest_d = est_q; ometh_d = meth_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q <= '0; newest_q <= '0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q <= fill_d; newest_q <= newest_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d; slot_q <= slot_d; cv_q <= cv_d; have_q <= have_d;
    hn_q <= hn_d; hp_q <= hp_d; exact_q <= exact_d;
    dts_q <= dts_d; cre_q <= cre_d; best_q <= best_d; est_q <= est_d; meth_q <= meth_d;
    nclk_q <= nclk_d; ndts_q <= ndts_d; pclk_q <= pclk_d; pdts_q <= pdts_d;
    oest_q <= oest_d; ometh_q <= ometh_d;
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = ovalid_q;
  assign clock_estimate_o = oest_q;
  assign method_o         = ometh_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FULL_CNT) else $error("fill count above depth");
  a_md_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_busy |-> state_q == ST_MUL) else $error("divider busy outside multiply state");
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && ometh_q == tce_pkg::METH_EMPTY) |-> oest_q == 64'd0)
    else $error("empty estimate not zero");
  a_meth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> ometh_q <= tce_pkg::METH_NEAREST) else $error("bad method code");

endmodule

// ===== tb/sv/timestamp_clock_estimator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_clock_estimator_tb
// Random and directed pushes and queries against a local estimator model;
// each estimate word is checked in order against the predicted word.
// ----------------------------------------------------------------------------
module timestamp_clock_estimator_tb;

  localparam int DEPTH = tce_pkg::STORE_DEPTH_DEF;
  localparam int WD_LIMIT = 20000;

  typedef struct packed {
    logic                     cmd;
    logic [tce_pkg::TS_W-1:0] dts;
    logic [tce_pkg::TS_W-1:0] sclk;
    logic                     cv;
    logic [tce_pkg::TS_W-1:0] created;
  } sample_word_t;

  typedef struct packed {
    logic [tce_pkg::EST_W-1:0]  est;
    logic [tce_pkg::METH_W-1:0] meth;
  } estimate_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic cmd_i = 1'b0;
  logic [tce_pkg::TS_W-1:0] dts_i = '0;
  logic [tce_pkg::TS_W-1:0] pair_clock_i = '0;
  logic created_valid_i = 1'b0;
  logic [tce_pkg::TS_W-1:0] created_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [tce_pkg::EST_W-1:0] clock_estimate_o;
  logic [tce_pkg::METH_W-1:0] method_o;

  timestamp_clock_estimator uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  sample_word_t pending_q[$];
  estimate_t    estimate_q[$];
  bit gen_done = 0;
  int errors = 0;
  int idle_cycles = 0;

  logic [63:0] ring_dts [DEPTH];
  logic [63:0] ring_clk [DEPTH];
  int newest = 0;
  int fill = 0;

  function automatic logic signed [63:0] ext(logic [tce_pkg::TS_W-1:0] v);
    return {v[tce_pkg::TS_W-1], v};
  endfunction

  function automatic logic signed [63:0] mag64(logic signed [63:0] a);
    return a[63] ? -a : a;
  endfunction

  task automatic estimate_clock(sample_word_t w);
    logic signed [63:0] d, c, cr, best, dd, crange, drange, num, idts;
    logic [127:0] prod, q;
    logic have, hp, hn, exact;
    int s, ps, ns;
    estimate_t r;
    d = ext(w.dts); c = ext(w.sclk); cr = ext(w.created);
    if (w.cmd == tce_pkg::CMD_PUSH) begin
      newest = (fill == 0) ? 0 : (newest + 1) % DEPTH;
      ring_dts[newest] = d;
      ring_clk[newest] = c;
      if (fill < DEPTH) fill++;
      return;
    end
    r.est = '0;
    if (!w.cv) begin
      if (fill == 0) r.meth = tce_pkg::METH_EMPTY;
      else begin
        have = 0; best = 0;
        for (int k = 0; k < fill; k++) begin
          s = (newest + DEPTH - k) % DEPTH;
          dd = mag64(d - ring_dts[s]);
          if (!have || $unsigned(dd) < $unsigned(best)) begin
            have = 1; best = dd;
            r.est = d - ring_dts[s] + ring_clk[s];
            if (dd == 0) break;
          end
        end
        r.meth = tce_pkg::METH_NEAREST;
      end
    end else if (fill == 0) begin
      r.est = cr; r.meth = tce_pkg::METH_CREATED;
    end else begin
      hp = 0; hn = 0; exact = 0; ps = 0; ns = 0; idts = d;
      for (int k = 0; k < fill; k++) begin
        s = (newest + DEPTH - k) % DEPTH;
        if (cr < $signed(ring_clk[s])) begin
          if (!hn || $signed(ring_clk[s]) < $signed(ring_clk[ns])) begin
            hn = 1; ns = s;
          end
        end else begin
          if (ring_dts[s] == d) exact = 1;
          hp = 1; ps = s;
          break;
        end
      end
      if (exact) begin
        r.est = ring_clk[ps]; r.meth = tce_pkg::METH_EXACT;
      end else begin
        if (hp && hn) begin
          crange = ring_clk[ns] - ring_clk[ps];
          drange = ring_dts[ns] - ring_dts[ps];
          num = ring_clk[ns] - cr;
          if (crange != 0 && !crange[63]) begin
            prod = {64'd0, num} * {64'd0, mag64(drange)};
            q = prod / {64'd0, crange};
            if (drange[63]) q = -q;
            idts = ring_dts[ns] - q[63:0];
          end
        end else if (hp) idts = ring_dts[ps];
        else if (hn) idts = ring_dts[ns];
        r.est = cr + (d - idts); r.meth = tce_pkg::METH_CBASED;
      end
    end
    estimate_q.push_back(r);
  endtask

  localparam longint TMAX = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam longint TMIN = -64'sh4000_0000_0000_0000;

  function automatic longint rnd_ts();
    longint v;
    v = longint'({$urandom, $urandom});
    case ($urandom_range(0, 5))
      0: v = TMAX;
      1: v = TMIN;
      2: v = longint'($urandom_range(0, 40));
      3: v = -longint'($urandom_range(0, 40));
      default: ;
    endcase
    return v;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? int'($urandom_range(20, 300))
                                       : int'($urandom_range(0, 3));
  endfunction

  task automatic add(logic cmd, longint d, longint c, logic cv, longint cr);
    sample_word_t w;
    w.cmd = cmd;
    w.dts = d[tce_pkg::TS_W-1:0];
    w.sclk = c[tce_pkg::TS_W-1:0];
    w.cv = cv;
    w.created = cr[tce_pkg::TS_W-1:0];
    pending_q.push_back(w);
  endtask

  initial begin
    longint base_d, base_c, step_d, step_c;
    add(tce_pkg::CMD_QUERY, 5, 0, 1'b0, 0);
    add(tce_pkg::CMD_QUERY, 5, 0, 1'b1, TMIN);
    add(tce_pkg::CMD_PUSH, 100, 1000, 1'b0, 0);
    add(tce_pkg::CMD_PUSH, 200, 2000, 1'b0, 0);
    add(tce_pkg::CMD_PUSH, 300, 3000, 1'b0, 0);
    add(tce_pkg::CMD_QUERY, 200, 0, 1'b0, 0);
    add(tce_pkg::CMD_QUERY, 250, 0, 1'b0, 0);
    add(tce_pkg::CMD_QUERY, TMAX, 0, 1'b0, 0);
    add(tce_pkg::CMD_QUERY, 200, 0, 1'b1, 2500);
    add(tce_pkg::CMD_QUERY, 150, 0, 1'b1, 1500);
    add(tce_pkg::CMD_QUERY, 1, 0, 1'b1, 500);
    add(tce_pkg::CMD_QUERY, 1, 0, 1'b1, 5000);
    add(tce_pkg::CMD_PUSH, TMAX, TMAX, 1'b0, 0);
    add(tce_pkg::CMD_PUSH, TMIN, TMIN, 1'b0, 0);
    add(tce_pkg::CMD_QUERY, TMIN, 0, 1'b0, 0);
    add(tce_pkg::CMD_QUERY, TMAX, 0, 1'b1, TMAX);
    add(tce_pkg::CMD_QUERY, TMIN, 0, 1'b1, TMIN);
    for (int i = 0; i < 18; i++) begin
      add(tce_pkg::CMD_PUSH, longint'(i * 7), longint'(i * 13), 1'b0, 0);
    end
    add(tce_pkg::CMD_QUERY, 50, 0, 1'b1, 100);
    for (int i = 0; i < 460; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        base_d = rnd_ts(); base_c = rnd_ts();
        step_d = longint'($urandom_range(0, 1000));
        step_c = longint'($urandom_range(0, 1000));
        repeat ($urandom_range(1, 20)) begin
          add(tce_pkg::CMD_PUSH, base_d, base_c, 1'($urandom), rnd_ts());
          base_d += step_d + longint'($urandom_range(0, 5));
          base_c += step_c + longint'($urandom_range(0, 5));
        end
        add(tce_pkg::CMD_QUERY, base_d - longint'($urandom_range(0, 5000)), rnd_ts(),
            1'b1, base_c - longint'($urandom_range(0, 8000)));
      end else if ($urandom_range(0, 1) != 0) begin
        add(tce_pkg::CMD_PUSH, rnd_ts(), rnd_ts(), 1'($urandom), rnd_ts());
      end else begin
        add(tce_pkg::CMD_QUERY, rnd_ts(), rnd_ts(), 1'($urandom), rnd_ts());
      end
    end
    gen_done = 1;
  end

  int in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) estimate_clock(pending_q.pop_front());
      if (in_valid_i && in_gap == 0) in_gap = gap_len();
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_valid_i <= 1'b1;
        cmd_i <= pending_q[0].cmd;
        dts_i <= pending_q[0].dts;
        pair_clock_i <= pending_q[0].sclk;
        created_valid_i <= pending_q[0].cv;
        created_i <= pending_q[0].created;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  int out_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    estimate_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (estimate_q.size() == 0) begin
          $error("estimate word with none expected");
          errors++;
        end else begin
          e = estimate_q.pop_front();
          if (clock_estimate_o !== e.est) begin
            $error("clock_estimate expected %h actual %h", e.est, clock_estimate_o);
            errors++;
          end
          if (method_o !== e.meth) begin
            $error("method expected %0d actual %0d", e.meth, method_o);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_gap = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (gen_done && pending_q.size() == 0 && !in_valid_i && estimate_q.size() == 0);
    repeat (500) @(posedge clk_i);
    if (errors == 0 && estimate_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
